// ===== hw/rtl/rgb_to_hsv_convert_unit_assert.svh =====
// Assertion macros shared by the RGB to HSV converter checker.
`ifndef RGB_TO_HSV_CONVERT_UNIT_ASSERT_SVH
`define RGB_TO_HSV_CONVERT_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RGBHSV_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgbhsv assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RGBHSV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgbhsv assertion failed");

`endif

// ===== hw/rtl/rgbhsv_pkg.sv =====
// Package with widths and types for the RGB to HSV converter.
package rgbhsv_pkg;

   // Field widths.
   localparam int COMP_BITS = 8;
   localparam int HUE_BITS  = 16;

   // Number of division cells: one quotient bit per cell for both dividers.
   localparam int STEPS = (HUE_BITS > COMP_BITS) ? HUE_BITS : COMP_BITS;

   // Hue divisor is six times delta, so it needs three extra bits.
   localparam int HDIV_BITS = COMP_BITS + 3;

   // Widths of the full dividends before they are split into remainder and quotient.
   localparam int HNUM_BITS = HDIV_BITS + STEPS;
   localparam int SNUM_BITS = COMP_BITS + STEPS;

   typedef struct packed {
      logic [COMP_BITS-1:0] red;
      logic [COMP_BITS-1:0] green;
      logic [COMP_BITS-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [HUE_BITS-1:0]  hue;
      logic [COMP_BITS-1:0] saturation;
      logic [COMP_BITS-1:0] brightness;
   } rsp_type;

   // Everything one cell hands to its neighbor.
   typedef struct packed {
      logic                 valid;
      logic                 gray;
      logic                 black;
      logic [COMP_BITS-1:0] brightness;
      logic [HDIV_BITS-1:0] h_rem;
      logic [HDIV_BITS-1:0] h_den;
      logic [STEPS-1:0]     h_nq;
      logic [COMP_BITS-1:0] s_rem;
      logic [COMP_BITS-1:0] s_den;
      logic [STEPS-1:0]     s_nq;
   } cell_type;

endpackage

// ===== hw/rtl/rgbhsv_front.sv =====
// Front stage: max, min, sector numerator and divider setup for one pixel.
module rgbhsv_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  rgbhsv_pkg::req_type  in_data,
   output rgbhsv_pkg::cell_type out_cell
);

   logic [rgbhsv_pkg::COMP_BITS-1:0] mx;
   logic [rgbhsv_pkg::COMP_BITS-1:0] mn;
   logic [rgbhsv_pkg::COMP_BITS-1:0] delta;
   logic [rgbhsv_pkg::HDIV_BITS-1:0] den6;
   logic signed [rgbhsv_pkg::HDIV_BITS:0] sd;
   logic signed [rgbhsv_pkg::HDIV_BITS:0] sr;
   logic signed [rgbhsv_pkg::HDIV_BITS:0] sg;
   logic signed [rgbhsv_pkg::HDIV_BITS:0] sb;
   logic signed [rgbhsv_pkg::HDIV_BITS:0] num;
   logic signed [rgbhsv_pkg::HDIV_BITS:0] num_fix;
   logic [rgbhsv_pkg::HDIV_BITS-1:0] unum;
   logic [rgbhsv_pkg::HNUM_BITS-1:0] hnum;
   logic [rgbhsv_pkg::SNUM_BITS-1:0] snum;
   rgbhsv_pkg::cell_type              cell_in;
   rgbhsv_pkg::cell_type              cell_ff;

   // Largest and smallest component.
   always_comb begin
      mx = in_data.red;
      mn = in_data.red;
      if (in_data.green > mx) mx = in_data.green;
      if (in_data.blue > mx) mx = in_data.blue;
      if (in_data.green < mn) mn = in_data.green;
      if (in_data.blue < mn) mn = in_data.blue;
   end

   assign delta = mx - mn;
   assign den6  = (rgbhsv_pkg::HDIV_BITS'(delta) << 2) + (rgbhsv_pkg::HDIV_BITS'(delta) << 1);

   // Sector numerator scaled by delta, wrapped into one full turn.
   assign sd = signed'({4'b0000, delta});
   assign sr = signed'({4'b0000, in_data.red});
   assign sg = signed'({4'b0000, in_data.green});
   assign sb = signed'({4'b0000, in_data.blue});

   always_comb begin
      if (in_data.red == mx) begin
         num = sg - sb;
      end else if (in_data.green == mx) begin
         num = (sd <<< 1) + sb - sr;
      end else begin
         num = (sd <<< 2) + sr - sg;
      end
      if (num < 0) begin
         num_fix = num + signed'({1'b0, den6});
      end else begin
         num_fix = num;
      end
   end

   assign unum = num_fix[rgbhsv_pkg::HDIV_BITS-1:0];

   // Dividends: numerator times 2^HUE_BITS for hue, FULL times delta for saturation.
   assign hnum = rgbhsv_pkg::HNUM_BITS'(unum) << rgbhsv_pkg::HUE_BITS;
   assign snum = (rgbhsv_pkg::SNUM_BITS'(delta) << rgbhsv_pkg::COMP_BITS)
               - rgbhsv_pkg::SNUM_BITS'(delta);

   // Split each dividend into the starting remainder and the bits still to shift in.
   always_comb begin
      cell_in.valid      = in_valid;
      cell_in.gray       = (delta == '0);
      cell_in.black      = (mx == '0);
      cell_in.brightness = mx;
      cell_in.h_rem      = hnum[rgbhsv_pkg::HNUM_BITS-1:rgbhsv_pkg::STEPS];
      cell_in.h_den      = den6;
      cell_in.h_nq       = hnum[rgbhsv_pkg::STEPS-1:0];
      cell_in.s_rem      = snum[rgbhsv_pkg::SNUM_BITS-1:rgbhsv_pkg::STEPS];
      cell_in.s_den      = mx;
      cell_in.s_nq       = snum[rgbhsv_pkg::STEPS-1:0];
   end

   // Stage register; only the valid bit needs reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign out_cell = cell_ff;

endmodule

// ===== hw/rtl/rgbhsv_cell.sv =====
// One division cell: a restoring step for hue and for saturation, then a register.
module rgbhsv_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  rgbhsv_pkg::cell_type in_cell,
   output rgbhsv_pkg::cell_type out_cell
);

   logic [rgbhsv_pkg::HDIV_BITS:0] h_sh;
   logic [rgbhsv_pkg::HDIV_BITS:0] h_diff;
   logic                           h_take;
   logic [rgbhsv_pkg::COMP_BITS:0] s_sh;
   logic [rgbhsv_pkg::COMP_BITS:0] s_diff;
   logic                           s_take;
   rgbhsv_pkg::cell_type           cell_in;
   rgbhsv_pkg::cell_type           cell_ff;

   // Shift the next dividend bit into each remainder and try the subtraction.
   assign h_sh   = {in_cell.h_rem, in_cell.h_nq[rgbhsv_pkg::STEPS-1]};
   assign h_diff = h_sh - {1'b0, in_cell.h_den};
   assign h_take = (h_sh >= {1'b0, in_cell.h_den});

   assign s_sh   = {in_cell.s_rem, in_cell.s_nq[rgbhsv_pkg::STEPS-1]};
   assign s_diff = s_sh - {1'b0, in_cell.s_den};
   assign s_take = (s_sh >= {1'b0, in_cell.s_den});

   // The remainder always drops below the divisor, so the top bit is discarded.
   always_comb begin
      cell_in       = in_cell;
      cell_in.h_rem = h_take ? h_diff[rgbhsv_pkg::HDIV_BITS-1:0]
                             : h_sh[rgbhsv_pkg::HDIV_BITS-1:0];
      cell_in.h_nq  = {in_cell.h_nq[rgbhsv_pkg::STEPS-2:0], h_take};
      cell_in.s_rem = s_take ? s_diff[rgbhsv_pkg::COMP_BITS-1:0]
                             : s_sh[rgbhsv_pkg::COMP_BITS-1:0];
      cell_in.s_nq  = {in_cell.s_nq[rgbhsv_pkg::STEPS-2:0], s_take};
   end

   // Cell register; only the valid bit needs reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign out_cell = cell_ff;

endmodule

// ===== hw/rtl/rgbhsv_outq.sv =====
// Two-entry output queue that decouples the cell chain from the result channel.
module rgbhsv_outq (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rgbhsv_pkg::rsp_type push_data,
   output logic                full,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rgbhsv_pkg::rsp_type rsp_data
);

   rgbhsv_pkg::rsp_type entry_ff [2];
   logic                wr_ptr_ff;
   logic                wr_ptr_in;
   logic                rd_ptr_ff;
   logic                rd_ptr_in;
   logic [1:0]          cnt_ff;
   logic [1:0]          cnt_in;
   logic                pop;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign full      = (cnt_ff == 2'd2);
   assign pop       = rsp_valid && !rsp_stall;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage for the waiting results.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/rgb_to_hsv_convert_unit.sv =====
// Throughput: one pixel per cycle; a front stage and a chain of STEPS division cells,
// each producing one quotient bit of hue and saturation, all advance together.
// The chain pauses only while the two-entry output queue is full and a result is ready.
// Reset clears the valid bits of every stage and empties the output queue.
module rgb_to_hsv_convert_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  rgbhsv_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rgbhsv_pkg::rsp_type rsp_data
);

   rgbhsv_pkg::cell_type chain [rgbhsv_pkg::STEPS+1];
   rgbhsv_pkg::rsp_type  result;
   logic                 en;
   logic                 q_full;
   logic                 push;

   // The whole chain moves unless the last cell holds a result the queue cannot take.
   assign en        = !(q_full && chain[rgbhsv_pkg::STEPS].valid);
   assign req_stall = !en;
   assign push      = en && chain[rgbhsv_pkg::STEPS].valid;

   rgbhsv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .in_data  (req_data),
      .out_cell (chain[0])
   );

   // Division cells, one quotient bit each.
   for (genvar i = 0; i < rgbhsv_pkg::STEPS; i++) begin : g_cell
      rgbhsv_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_cell  (chain[i]),
         .out_cell (chain[i+1])
      );
   end

   // Gray pixels have no hue and black pixels have no saturation.
   always_comb begin
      result.hue        = chain[rgbhsv_pkg::STEPS].gray ? '0
                        : chain[rgbhsv_pkg::STEPS].h_nq[rgbhsv_pkg::HUE_BITS-1:0];
      result.saturation = chain[rgbhsv_pkg::STEPS].black ? '0
                        : chain[rgbhsv_pkg::STEPS].s_nq[rgbhsv_pkg::COMP_BITS-1:0];
      result.brightness = chain[rgbhsv_pkg::STEPS].brightness;
   end

   rgbhsv_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .full      (q_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/rgbhsv_checker.sv =====
// Port-level checker for the RGB to HSV converter and its bind statement.
`include "rgb_to_hsv_convert_unit_assert.svh"

module rgbhsv_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input rgbhsv_pkg::req_type req_data,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input rgbhsv_pkg::rsp_type rsp_data
);

   // A stalled result transaction keeps its valid and its payload.
   `RGBHSV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // Input is held back only while the output queue has a result waiting.
   `RGBHSV_ASSERT_SAME(a_stall_needs_rsp, clock, reset, req_stall, rsp_valid)

   // Zero saturation means a gray pixel, which carries no hue.
   `RGBHSV_ASSERT_SAME(a_gray_hue, clock, reset, rsp_valid && rsp_data.saturation == '0, rsp_data.hue == '0)

   // A black pixel has neither saturation nor hue.
   `RGBHSV_ASSERT_SAME(a_black, clock, reset, rsp_valid && rsp_data.brightness == '0, rsp_data.saturation == '0 && rsp_data.hue == '0)

endmodule

bind rgb_to_hsv_convert_unit rgbhsv_checker u_checker (.*);
